// ===== sv/led_matrix_channel_mapper_core_defines.svh =====
// Assertion macros shared by the channel mapper checker.
`ifndef LED_MATRIX_CHANNEL_MAPPER_CORE_DEFINES_SVH
`define LED_MATRIX_CHANNEL_MAPPER_CORE_DEFINES_SVH

// Same-cycle implication, skipped while reset is high.
`define LMCM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication; pass 1'b0 as rst to keep it live during reset.
`define LMCM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/lmcm_pkg.sv =====
// Shared types and constants of the LED matrix channel mapper.
package lmcm_pkg;

   localparam int MAX_SIDE_DEF  = 128;
   localparam int UNIVERSE_SIZE = 512;
   localparam int CH_W          = $clog2(UNIVERSE_SIZE);
   localparam int QUEUE_DEPTH   = 4;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 9;

   typedef enum logic [2:0] {
      REG_WIDTH,
      REG_HEIGHT,
      REG_COL_MAJOR,
      REG_SERPENTINE,
      REG_COLOR_ORDER,
      REG_BRIGHTNESS,
      REG_START_CHANNEL,
      REG_START_UNIVERSE
   } csr_index_type;

   typedef enum logic [2:0] {
      ORDER_RGB,
      ORDER_GRB,
      ORDER_BRG,
      ORDER_RBG,
      ORDER_GBR,
      ORDER_BGR
   } color_order_type;

   typedef logic [1:0] beat_type;
   localparam beat_type FIRST_BEAT = 2'd0;
   localparam beat_type LAST_BEAT  = 2'd2;

   // Three output bytes of one pixel, element 0 goes out first.
   typedef logic [2:0][7:0] comp_type;

   typedef struct packed {
      logic [7:0] matrix_width;
      logic [7:0] matrix_height;
      logic       column_major;
      logic       serpentine;
      logic [2:0] color_order;
      logic [7:0] brightness;
      logic [8:0] start_channel;
      logic [7:0] start_universe;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      matrix_width:   8'd16,
      matrix_height:  8'd16,
      column_major:   1'b0,
      serpentine:     1'b0,
      color_order:    3'd0,
      brightness:     8'd255,
      start_channel:  9'd0,
      start_universe: 8'd0
   };

endpackage

// ===== sv/lmcm_ifs.sv =====
// Valid/ready channel interfaces for pixels in and channel writes out.
interface lmcm_pixel_if;
   logic       valid;
   logic       ready;
   logic [6:0] pixel_x;
   logic [6:0] pixel_y;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, pixel_x, pixel_y, red, green, blue, input ready);
   modport sink   (input valid, pixel_x, pixel_y, red, green, blue, output ready);
endinterface

interface lmcm_chan_if;
   logic       valid;
   logic       ready;
   logic [6:0] universe_offset;
   logic [7:0] universe_number;
   logic [8:0] channel;
   logic [7:0] channel_byte;
   logic       last_of_pixel;

   modport source (output valid, universe_offset, universe_number, channel, channel_byte,
                   last_of_pixel, input ready);
   modport sink   (input valid, universe_offset, universe_number, channel, channel_byte,
                   last_of_pixel, output ready);
endinterface

// ===== sv/led_matrix_channel_mapper_core.sv =====
// Top level of the LED matrix to DMX512 channel mapper.
// Usage:
//  - req carries one pixel per beat (column, row, red, green, blue).
//  - rsp carries channel writes: three beats per pixel inside the matrix,
//    the third one flagged last_of_pixel; pixels outside the matrix give none.
//  - csr_we/csr_index/csr_wdata write the configuration registers; write only
//    while no pixel is in flight.
// Path: an accepted pixel passes the front-end stage register and the queue,
// and each of its beats then enters the output register as that frees up.
// Throughput: the output register issues one beat per cycle while the receiver
// is ready, three beats per pixel; a four-entry queue between the front end
// and the beat serializer lets the front take pixels while beats wait.
// Reset clears the pipeline and queue and loads the register defaults
// (16 x 16 row-major, RGB, full brightness, universe 0, channel 0).
// When the receiver stalls, the current beat holds, the queue fills and
// req.ready drops once no entry is left for a new pixel.
module led_matrix_channel_mapper_core #(
   parameter int MAX_SIDE = lmcm_pkg::MAX_SIDE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   lmcm_pixel_if.sink                      req,
   lmcm_chan_if.source                     rsp,
   input  logic                            csr_we,
   input  logic [lmcm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lmcm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lmcm_pkg::*;

   localparam int LIN_W  = $clog2(UNIVERSE_SIZE + 3 * MAX_SIDE * MAX_SIDE);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int DATA_W = LIN_W + $bits(comp_type);

   cfg_type           cfg_ff, cfg_in;
   logic              push;
   logic [LIN_W-1:0]  push_lin;
   comp_type          push_comp;
   logic              pop;
   logic [DATA_W-1:0] head_data;
   logic              head_valid;
   logic [CNT_W-1:0]  q_count;
   logic [LIN_W-1:0]  head_lin;
   comp_type          head_comp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_WIDTH:          cfg_in.matrix_width   = csr_wdata[7:0];
            REG_HEIGHT:         cfg_in.matrix_height  = csr_wdata[7:0];
            REG_COL_MAJOR:      cfg_in.column_major   = csr_wdata[0];
            REG_SERPENTINE:     cfg_in.serpentine     = csr_wdata[0];
            REG_COLOR_ORDER:    cfg_in.color_order    = csr_wdata[2:0];
            REG_BRIGHTNESS:     cfg_in.brightness     = csr_wdata[7:0];
            REG_START_CHANNEL:  cfg_in.start_channel  = csr_wdata[8:0];
            REG_START_UNIVERSE: cfg_in.start_universe = csr_wdata[7:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lmcm_front #(
      .MAX_SIDE (MAX_SIDE),
      .LIN_W    (LIN_W),
      .CNT_W    (CNT_W),
      .DEPTH    (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cfg       (cfg_ff),
      .q_count   (q_count),
      .push      (push),
      .push_lin  (push_lin),
      .push_comp (push_comp)
   );

   lmcm_queue #(
      .DATA_W (DATA_W),
      .DEPTH  (QUEUE_DEPTH),
      .CNT_W  (CNT_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_lin, push_comp}),
      .pop       (pop),
      .head_data (head_data),
      .not_empty (head_valid),
      .count     (q_count)
   );

   assign head_lin  = head_data[DATA_W-1:$bits(comp_type)];
   assign head_comp = comp_type'(head_data[$bits(comp_type)-1:0]);

   lmcm_back #(
      .LIN_W (LIN_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_lin   (head_lin),
      .head_comp  (head_comp),
      .pop        (pop),
      .rsp        (rsp)
   );

endmodule

// ===== sv/lmcm_front.sv =====
// Front end: accepts pixels, checks bounds, builds the wiring index and scaled bytes.
module lmcm_front #(
   parameter int MAX_SIDE = 128,
   parameter int LIN_W    = 16,
   parameter int CNT_W    = 3,
   parameter int DEPTH    = 4
) (
   input  logic               clock,
   input  logic               reset,
   lmcm_pixel_if.sink         req,
   input  lmcm_pkg::cfg_type  cfg,
   input  logic [CNT_W-1:0]   q_count,
   output logic               push,
   output logic [LIN_W-1:0]   push_lin,
   output lmcm_pkg::comp_type push_comp
);
   import lmcm_pkg::*;

   localparam int IDX_W = $clog2(MAX_SIDE * MAX_SIDE + 1);

   function automatic logic [7:0] div255(input logic [15:0] n);
      logic [15:0] t;
      t = n + (n >> 8) + 16'd1;
      return t[15:8];
   endfunction

   logic [7:0]        w_clamp;
   logic [7:0]        h_clamp;
   logic              in_matrix;
   logic [6:0]        line;
   logic [6:0]        along;
   logic [7:0]        len;
   logic [7:0]        rev;
   logic [14:0]       prod_full;
   logic              accept;
   logic [IDX_W-1:0]  idx;
   logic [7:0]        r_s;
   logic [7:0]        g_s;
   logic [7:0]        b_s;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_inside_ff, s1_inside_in;
   logic [IDX_W-1:0]  s1_prod_ff, s1_prod_in;
   logic [6:0]        s1_pos_ff, s1_pos_in;
   logic [2:0][15:0]  s1_scaled_ff, s1_scaled_in;

   // Leave room in the queue for the pixel already in the stage register.
   assign req.ready = ((CNT_W+1)'(q_count) + (CNT_W+1)'(s1_valid_ff)) < (CNT_W+1)'(DEPTH);
   assign accept    = req.valid && req.ready;

   always_comb begin
      w_clamp   = (cfg.matrix_width > 8'(MAX_SIDE)) ? 8'(MAX_SIDE) : cfg.matrix_width;
      h_clamp   = (cfg.matrix_height > 8'(MAX_SIDE)) ? 8'(MAX_SIDE) : cfg.matrix_height;
      in_matrix = ({1'b0, req.pixel_x} < w_clamp) && ({1'b0, req.pixel_y} < h_clamp);
      if (cfg.column_major) begin
         line  = req.pixel_x;
         along = req.pixel_y;
         len   = h_clamp;
      end else begin
         line  = req.pixel_y;
         along = req.pixel_x;
         len   = w_clamp;
      end
      rev       = len - 8'd1 - {1'b0, along};
      prod_full = 15'(line) * 15'(len);

      s1_valid_in     = accept;
      s1_inside_in    = in_matrix;
      s1_prod_in      = IDX_W'(prod_full);
      s1_pos_in       = (cfg.serpentine && line[0]) ? rev[6:0] : along;
      s1_scaled_in[0] = 16'(req.red) * 16'(cfg.brightness);
      s1_scaled_in[1] = 16'(req.green) * 16'(cfg.brightness);
      s1_scaled_in[2] = 16'(req.blue) * 16'(cfg.brightness);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_inside_ff <= s1_inside_in;
         s1_prod_ff   <= s1_prod_in;
         s1_pos_ff    <= s1_pos_in;
         s1_scaled_ff <= s1_scaled_in;
      end
   end

   always_comb begin
      idx      = s1_prod_ff + IDX_W'(s1_pos_ff);
      push_lin = LIN_W'(cfg.start_channel) + LIN_W'(idx) + (LIN_W'(idx) << 1);
      r_s      = div255(s1_scaled_ff[0] + 16'd127);
      g_s      = div255(s1_scaled_ff[1] + 16'd127);
      b_s      = div255(s1_scaled_ff[2] + 16'd127);
      unique case (color_order_type'(cfg.color_order))
         ORDER_GRB: push_comp = {b_s, r_s, g_s};
         ORDER_BRG: push_comp = {g_s, r_s, b_s};
         ORDER_RBG: push_comp = {g_s, b_s, r_s};
         ORDER_GBR: push_comp = {r_s, b_s, g_s};
         ORDER_BGR: push_comp = {r_s, g_s, b_s};
         default:   push_comp = {b_s, g_s, r_s};
      endcase
      // Pixels outside the matrix are dropped here and never reach the queue.
      push = s1_valid_ff && s1_inside_ff;
   end

endmodule

// ===== sv/lmcm_queue.sv =====
// Small first-in first-out queue of mapped pixels between front and back end.
module lmcm_queue #(
   parameter int DATA_W = 40,
   parameter int DEPTH  = 4,
   parameter int CNT_W  = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] head_data,
   output logic              not_empty,
   output logic [CNT_W-1:0]  count
);
   localparam int PTR_W = $clog2(DEPTH);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data = mem[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule

// ===== sv/lmcm_back.sv =====
// Back end: turns one queued pixel into three registered channel-write beats.
module lmcm_back #(
   parameter int LIN_W = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  lmcm_pkg::cfg_type  cfg,
   input  logic               head_valid,
   input  logic [LIN_W-1:0]   head_lin,
   input  lmcm_pkg::comp_type head_comp,
   output logic               pop,
   lmcm_chan_if.source        rsp
);
   import lmcm_pkg::*;

   localparam int UOFF_W = LIN_W - CH_W;

   logic              load;
   logic [LIN_W-1:0]  lin;
   logic [UOFF_W-1:0] uoff;

   logic              rsp_valid_ff, rsp_valid_in;
   beat_type          beat_ff, beat_in;
   logic [6:0]        uoff_ff;
   logic [7:0]        univ_ff;
   logic [8:0]        ch_ff;
   logic [7:0]        byte_ff;
   logic              last_ff;

   always_comb begin
      // The output register takes a new beat when empty or being drained.
      load = head_valid && (!rsp_valid_ff || rsp.ready);
      lin  = head_lin + LIN_W'(beat_ff);
      uoff = lin[LIN_W-1:CH_W];
      pop  = load && (beat_ff == LAST_BEAT);

      rsp_valid_in = rsp_valid_ff;
      beat_in      = beat_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         beat_in      = (beat_ff == LAST_BEAT) ? FIRST_BEAT : beat_ff + 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         beat_ff      <= FIRST_BEAT;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         beat_ff      <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         uoff_ff <= 7'(uoff);
         univ_ff <= cfg.start_universe + 8'(uoff);
         ch_ff   <= lin[CH_W-1:0];
         byte_ff <= head_comp[beat_ff];
         last_ff <= (beat_ff == LAST_BEAT);
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.universe_offset = uoff_ff;
   assign rsp.universe_number = univ_ff;
   assign rsp.channel         = ch_ff;
   assign rsp.channel_byte    = byte_ff;
   assign rsp.last_of_pixel   = last_ff;

endmodule

// ===== sv/lmcm_checker.sv =====
// Port-level checker of the channel mapper and its bind to the top level.
`include "led_matrix_channel_mapper_core_defines.svh"

module lmcm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] rsp_uoff,
   input logic [8:0] rsp_channel,
   input logic [7:0] rsp_byte,
   input logic       rsp_last
);
   logic       rsp_fire;
   logic [1:0] beat_cnt_ff, beat_cnt_in;
   logic [8:0] prev_ch_ff;
   logic [6:0] prev_uoff_ff;

   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      beat_cnt_in = beat_cnt_ff;
      if (rsp_fire) begin
         beat_cnt_in = rsp_last ? 2'd0 : beat_cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_cnt_ff <= 2'd0;
      end else begin
         beat_cnt_ff <= beat_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_fire) begin
         prev_ch_ff   <= rsp_channel;
         prev_uoff_ff <= rsp_uoff;
      end
   end

   `LMCM_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid, "beat valid right after reset")

   `LMCM_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_channel) && $stable(rsp_byte) && $stable(rsp_last) && $stable(rsp_uoff), "stalled beat changed")

   `LMCM_ASSERT_SAME(a_last_third, clock, reset, rsp_fire, rsp_last == (beat_cnt_ff == 2'd2), "last flag not on third beat of a pixel")

   `LMCM_ASSERT_SAME(a_chan_step, clock, reset, rsp_fire && (beat_cnt_ff != 2'd0), (rsp_channel == prev_ch_ff + 9'd1) && (rsp_uoff == ((prev_ch_ff == 9'd511) ? prev_uoff_ff + 7'd1 : prev_uoff_ff)), "channel of a pixel beat does not follow the previous one")

endmodule

bind led_matrix_channel_mapper_core lmcm_checker u_lmcm_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_uoff    (rsp.universe_offset),
   .rsp_channel (rsp.channel),
   .rsp_byte    (rsp.channel_byte),
   .rsp_last    (rsp.last_of_pixel)
);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the LED matrix to DMX512 channel mapper core.
`timescale 1ns / 1ps

module tb;
   import lmcm_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 12;
   localparam int END_CYCLES    = 24;
   localparam int RANDOM_PIXELS = 440;
   localparam int QUIET_FROM    = 400;
   localparam int PHASE_PIXELS  = 40;
   localparam int DIR_ROWS      = 45;

   // Color order codes without a name of their own; both fall back to RGB.
   localparam logic [2:0] ORDER_SPARE_LO = 3'd6;
   localparam logic [2:0] ORDER_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [6:0] x;
      logic [6:0] y;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [6:0] universe_offset;
      logic [7:0] universe_number;
      logic [8:0] channel;
      logic [7:0] channel_byte;
      logic       last_of_pixel;
   } chan_write_type;

   typedef enum logic [1:0] {ROW_CSR, ROW_PIXEL, ROW_TYPED, ROW_DROP} row_kind_type;

   // Typed rows give the first beat's universe and channel and all three bytes.
   typedef struct {
      row_kind_type  kind;
      csr_index_type reg_idx;
      int            reg_val;
      int            x;
      int            y;
      int            r;
      int            g;
      int            b;
      int            t_uoff;
      int            t_unum;
      int            t_chan;
      int            t_b0;
      int            t_b1;
      int            t_b2;
   } dir_row_type;

   dir_row_type dir_table [DIR_ROWS] = '{
      '{ROW_TYPED, REG_WIDTH, 0,   0,   0, 255,   0, 128, 0, 0,   0, 255,   0, 128},
      '{ROW_TYPED, REG_WIDTH, 0,  15,  15,   1,   2,   3, 1, 1, 253,   1,   2,   3},
      '{ROW_DROP,  REG_WIDTH, 0,  16,   0,   9,   9,   9, 0, 0,   0,   0,   0,   0},
      '{ROW_DROP,  REG_WIDTH, 0,   0,  16,   9,   9,   9, 0, 0,   0,   0,   0,   0},
      '{ROW_DROP,  REG_WIDTH, 0, 127, 127, 255, 255, 255, 0, 0,   0,   0,   0,   0},
      '{ROW_PIXEL, REG_WIDTH, 0,   5,   3, 'h5A, 'hA5, 'h0F, 0, 0, 0,   0,   0,   0},
      '{ROW_CSR, REG_COLOR_ORDER, ORDER_GRB, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_TYPED, REG_WIDTH, 0, 0, 0, 'h11, 'h22, 'h33, 0, 0, 0, 'h22, 'h11, 'h33},
      '{ROW_CSR, REG_COLOR_ORDER, ORDER_BRG, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_TYPED, REG_WIDTH, 0, 0, 0, 'h11, 'h22, 'h33, 0, 0, 0, 'h33, 'h11, 'h22},
      '{ROW_CSR, REG_COLOR_ORDER, ORDER_RBG, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_TYPED, REG_WIDTH, 0, 0, 0, 'h11, 'h22, 'h33, 0, 0, 0, 'h11, 'h33, 'h22},
      '{ROW_CSR, REG_COLOR_ORDER, ORDER_GBR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_TYPED, REG_WIDTH, 0, 0, 0, 'h11, 'h22, 'h33, 0, 0, 0, 'h22, 'h33, 'h11},
      '{ROW_CSR, REG_COLOR_ORDER, ORDER_BGR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_TYPED, REG_WIDTH, 0, 0, 0, 'h11, 'h22, 'h33, 0, 0, 0, 'h33, 'h22, 'h11},
      '{ROW_CSR, REG_COLOR_ORDER, ORDER_SPARE_LO, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_TYPED, REG_WIDTH, 0, 0, 0, 'h11, 'h22, 'h33, 0, 0, 0, 'h11, 'h22, 'h33},
      '{ROW_CSR, REG_COLOR_ORDER, ORDER_SPARE_HI, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_TYPED, REG_WIDTH, 0, 0, 0, 'h11, 'h22, 'h33, 0, 0, 0, 'h11, 'h22, 'h33},
      '{ROW_CSR, REG_COLOR_ORDER, ORDER_RGB, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_CSR,   REG_BRIGHTNESS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_TYPED, REG_WIDTH, 0, 3, 2, 255, 255, 255, 0, 0, 105, 0, 0, 0},
      '{ROW_CSR,   REG_BRIGHTNESS, 128, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_PIXEL, REG_WIDTH, 0, 1, 1, 255, 128, 1, 0, 0, 0, 0, 0, 0},
      '{ROW_CSR,   REG_BRIGHTNESS, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_CSR,   REG_SERPENTINE, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_TYPED, REG_WIDTH, 0, 0, 1, 10, 20, 30, 0, 0, 93, 10, 20, 30},
      '{ROW_CSR,   REG_COL_MAJOR, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_TYPED, REG_WIDTH, 0, 1, 0, 40, 50, 60, 0, 0, 93, 40, 50, 60},
      '{ROW_CSR,   REG_WIDTH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_DROP,  REG_WIDTH, 0, 0, 0, 7, 7, 7, 0, 0, 0, 0, 0, 0},
      '{ROW_CSR,   REG_WIDTH, 'h1C8, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_PIXEL, REG_WIDTH, 0, 127, 15, 200, 100, 50, 0, 0, 0, 0, 0, 0},
      '{ROW_CSR,   REG_HEIGHT, 'h0FF, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_PIXEL, REG_WIDTH, 0, 127, 127, 1, 254, 127, 0, 0, 0, 0, 0, 0},
      '{ROW_CSR,   REG_HEIGHT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_DROP,  REG_WIDTH, 0, 0, 0, 7, 7, 7, 0, 0, 0, 0, 0, 0},
      '{ROW_CSR,   REG_HEIGHT, 128, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_CSR,   REG_START_CHANNEL, 511, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_CSR,   REG_START_UNIVERSE, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_PIXEL, REG_WIDTH, 0, 0, 0, 255, 0, 255, 0, 0, 0, 0, 0, 0},
      '{ROW_PIXEL, REG_WIDTH, 0, 127, 127, 0, 255, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_CSR,   REG_COL_MAJOR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_PIXEL, REG_WIDTH, 0, 126, 127, 85, 170, 51, 0, 0, 0, 0, 0, 0}
   };

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [2:0] csr_index;
   logic [8:0] csr_wdata;

   lmcm_pixel_if pixel_bus ();
   lmcm_chan_if  write_bus ();

   cfg_type        mapper_cfg;
   chan_write_type pending_writes [$];
   int             mismatches;
   int             cycle_count;
   bit             quiet;
   int             rsp_stall;

   led_matrix_channel_mapper_core dut (
      .clock     (clock),
      .reset     (reset),
      .req       (pixel_bus),
      .rsp       (write_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("led_matrix_channel_mapper_core verification failed");
         $finish;
      end
   end

   function automatic int unsigned clamp_side(logic [7:0] side);
      return (side > MAX_SIDE_DEF) ? MAX_SIDE_DEF : side;
   endfunction

   function automatic logic [7:0] scale_component(logic [7:0] c);
      return 8'((32'(c) * mapper_cfg.brightness + 127) / 255);
   endfunction

   // Queues the three channel writes of a pixel; nothing when it falls outside.
   function automatic void map_pixel(pixel_type p);
      int unsigned    w;
      int unsigned    h;
      int unsigned    pos;
      int unsigned    idx;
      int unsigned    lin;
      logic [7:0]     sr;
      logic [7:0]     sg;
      logic [7:0]     sb;
      comp_type       bytes;
      chan_write_type beat;
      w = clamp_side(mapper_cfg.matrix_width);
      h = clamp_side(mapper_cfg.matrix_height);
      if (p.x >= w || p.y >= h) return;
      if (mapper_cfg.column_major) begin
         pos = (mapper_cfg.serpentine && p.x[0]) ? h - 1 - p.y : p.y;
         idx = p.x * h + pos;
      end else begin
         pos = (mapper_cfg.serpentine && p.y[0]) ? w - 1 - p.x : p.x;
         idx = p.y * w + pos;
      end
      sr = scale_component(p.red);
      sg = scale_component(p.green);
      sb = scale_component(p.blue);
      case (mapper_cfg.color_order)
         ORDER_GRB: bytes = '{sb, sr, sg};
         ORDER_BRG: bytes = '{sg, sr, sb};
         ORDER_RBG: bytes = '{sg, sb, sr};
         ORDER_GBR: bytes = '{sr, sb, sg};
         ORDER_BGR: bytes = '{sr, sg, sb};
         default:   bytes = '{sb, sg, sr};
      endcase
      for (int k = 0; k < 3; k++) begin
         lin = mapper_cfg.start_channel + idx * 3 + k;
         beat.universe_offset = 7'(lin / UNIVERSE_SIZE);
         beat.universe_number = 8'(mapper_cfg.start_universe + lin / UNIVERSE_SIZE);
         beat.channel         = 9'(lin % UNIVERSE_SIZE);
         beat.channel_byte    = bytes[k];
         beat.last_of_pixel   = (k == LAST_BEAT);
         pending_writes.push_back(beat);
      end
   endfunction

   function automatic logic [8:0] pick_reg_value(csr_index_type idx);
      int unsigned roll;
      roll = $urandom_range(0, 19);
      case (idx) inside
         REG_WIDTH, REG_HEIGHT: begin
            // Mostly legal sizes, with zero and oversize values now and then.
            if (roll == 0) return 9'd0;
            else if (roll < 3) return 9'd1;
            else if (roll < 5) return 9'd128;
            else if (roll < 7) return 9'($urandom_range(129, 511));
            else if (roll < 13) return 9'($urandom_range(2, 16));
            else return 9'($urandom_range(1, 127));
         end
         REG_BRIGHTNESS, REG_START_CHANNEL, REG_START_UNIVERSE: begin
            if (roll < 4) return 9'd0;
            else if (roll < 8) return (idx == REG_START_CHANNEL) ? 9'd511 : 9'd255;
            else return 9'($urandom_range(0, 511));
         end
         default: return 9'($urandom_range(0, 511));
      endcase
   endfunction

   function automatic void check_field(string name, logic [8:0] want, logic [8:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   task automatic csr_write(csr_index_type idx, logic [8:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_WIDTH:          mapper_cfg.matrix_width   = value[7:0];
         REG_HEIGHT:         mapper_cfg.matrix_height  = value[7:0];
         REG_COL_MAJOR:      mapper_cfg.column_major   = value[0];
         REG_SERPENTINE:     mapper_cfg.serpentine     = value[0];
         REG_COLOR_ORDER:    mapper_cfg.color_order    = value[2:0];
         REG_BRIGHTNESS:     mapper_cfg.brightness     = value[7:0];
         REG_START_CHANNEL:  mapper_cfg.start_channel  = value;
         REG_START_UNIVERSE: mapper_cfg.start_universe = value[7:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Pixels outside the matrix leave nothing to wait for, hence the extra cycles.
   task automatic wait_drained(int settle);
      pixel_bus.valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic send_pixel(input pixel_type p, input bit predict);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         pixel_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      pixel_bus.valid   <= 1'b1;
      pixel_bus.pixel_x <= p.x;
      pixel_bus.pixel_y <= p.y;
      pixel_bus.red     <= p.red;
      pixel_bus.green   <= p.green;
      pixel_bus.blue    <= p.blue;
      do @(posedge clock); while (pixel_bus.ready !== 1'b1);
      if (predict) map_pixel(p);
   endtask

   initial begin : receiver
      rsp_stall = 0;
      write_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_stall > 0) rsp_stall--;
         else if (!quiet && $urandom_range(0, 5) == 0) rsp_stall = $urandom_range(1, 13);
         write_bus.ready <= (rsp_stall == 0);
      end
   end

   always @(posedge clock) begin : write_checker
      chan_write_type want;
      if (!reset && write_bus.valid === 1'b1 && write_bus.ready === 1'b1) begin
         if (pending_writes.size() == 0) begin
            $display("%0t: channel write expected none actual universe %0d channel %0d byte %0d",
                     $time, write_bus.universe_number, write_bus.channel,
                     write_bus.channel_byte);
            mismatches++;
         end else begin
            want = pending_writes.pop_front();
            check_field("universe_offset", 9'(want.universe_offset),
                        9'(write_bus.universe_offset));
            check_field("universe_number", 9'(want.universe_number),
                        9'(write_bus.universe_number));
            check_field("channel", want.channel, write_bus.channel);
            check_field("channel_byte", 9'(want.channel_byte), 9'(write_bus.channel_byte));
            check_field("last_of_pixel", 9'(want.last_of_pixel),
                        9'(write_bus.last_of_pixel));
         end
      end
   end

   initial begin : stimulus
      pixel_type      pix;
      chan_write_type beat;
      int             sent_pixels;
      int             phase;
      int unsigned    side_w;
      int unsigned    side_h;
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= REG_WIDTH;
      csr_wdata         <= '0;
      pixel_bus.valid   <= 1'b0;
      pixel_bus.pixel_x <= '0;
      pixel_bus.pixel_y <= '0;
      pixel_bus.red     <= '0;
      pixel_bus.green   <= '0;
      pixel_bus.blue    <= '0;
      mismatches        = 0;
      sent_pixels       = 0;
      quiet             = 1'b0;
      mapper_cfg        = CFG_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) begin
         pix.x     = 7'(dir_table[i].x);
         pix.y     = 7'(dir_table[i].y);
         pix.red   = 8'(dir_table[i].r);
         pix.green = 8'(dir_table[i].g);
         pix.blue  = 8'(dir_table[i].b);
         case (dir_table[i].kind)
            ROW_CSR: begin
               wait_drained(SETTLE_CYCLES);
               csr_write(dir_table[i].reg_idx, 9'(dir_table[i].reg_val));
            end
            ROW_PIXEL: send_pixel(pix, 1'b1);
            ROW_TYPED: begin
               send_pixel(pix, 1'b0);
               for (int k = 0; k < 3; k++) begin
                  beat.universe_offset = 7'(dir_table[i].t_uoff);
                  beat.universe_number = 8'(dir_table[i].t_unum);
                  beat.channel         = 9'(dir_table[i].t_chan + k);
                  beat.channel_byte    = (k == FIRST_BEAT) ? 8'(dir_table[i].t_b0) :
                                         (k == LAST_BEAT)  ? 8'(dir_table[i].t_b2) :
                                                             8'(dir_table[i].t_b1);
                  beat.last_of_pixel   = (k == LAST_BEAT);
                  pending_writes.push_back(beat);
               end
            end
            default: send_pixel(pix, 1'b0);
         endcase
      end

      phase = 0;
      while (sent_pixels < RANDOM_PIXELS) begin
         wait_drained(SETTLE_CYCLES);
         quiet = (sent_pixels >= QUIET_FROM) || ($urandom_range(0, 4) == 0);
         for (int r = 0; r < 8; r++)
            csr_write(csr_index_type'(r), pick_reg_value(csr_index_type'(r)));
         side_w = clamp_side(mapper_cfg.matrix_width);
         side_h = clamp_side(mapper_cfg.matrix_height);
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            // Hold the sender back until the block has nothing left to deliver.
            if (n == PHASE_PIXELS / 2 && (phase == 0 || $urandom_range(0, 2) == 0))
               wait_drained(1);
            if (side_w > 0 && side_h > 0 && $urandom_range(0, 6) != 0) begin
               pix.x = 7'($urandom_range(0, side_w - 1));
               pix.y = 7'($urandom_range(0, side_h - 1));
            end else begin
               pix.x = 7'($urandom_range(0, 127));
               pix.y = 7'($urandom_range(0, 127));
            end
            pix.red   = 8'($urandom_range(0, 255));
            pix.green = 8'($urandom_range(0, 255));
            pix.blue  = 8'($urandom_range(0, 255));
            send_pixel(pix, 1'b1);
            sent_pixels++;
         end
         phase++;
      end

      wait_drained(END_CYCLES);
      if (mismatches == 0) begin
         $display("led_matrix_channel_mapper_core verification clean");
      end else begin
         $display("led_matrix_channel_mapper_core verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/lmcm_pkg.sv
sv/lmcm_ifs.sv
sv/lmcm_front.sv
sv/lmcm_queue.sv
sv/lmcm_back.sv
sv/led_matrix_channel_mapper_core.sv
sv/lmcm_checker.sv
tb/sv/tb.sv
